### src/ccf_pkg.sv
package ccf_pkg;

  localparam int CH_W      = 3;
  localparam int TDC_W     = 15;
  localparam int WIN_W     = 8;
  localparam int MINH_W    = 4;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS = 2'd2;

  localparam logic [WIN_W-1:0]  WINDOW_RST = 8'd16;
  localparam logic [MINH_W-1:0] MINH_RST   = 4'd4;
  localparam logic [MINH_W-1:0] MINH_FLOOR = 4'd2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RK_LD,
    ST_RK_CUR,
    ST_RK_CMP,
    ST_SR_LO,
    ST_SR_HI,
    ST_SR_CMP,
    ST_EM_RD,
    ST_EM_WAIT
  } state_t;

endpackage

### src/ccf_hit_if.sv
interface ccf_hit_if;
  logic                       valid;
  logic                       ready;
  logic [ccf_pkg::CH_W-1:0]   channel;
  logic [ccf_pkg::TDC_W-1:0]  tdc_count;
  logic                       last;

  modport source (output valid, channel, tdc_count, last, input ready);
  modport sink   (input valid, channel, tdc_count, last, output ready);
endinterface

### src/ccf_res_if.sv
interface ccf_res_if;
  logic                     valid;
  logic                     ready;
  logic [ccf_pkg::CH_W-1:0] hit_channel;
  logic                     crosstalk;
  logic                     overflow;
  logic                     last_result;

  modport source (output valid, hit_channel, crosstalk, overflow, last_result, input ready);
  modport sink   (input valid, hit_channel, crosstalk, overflow, last_result, output ready);
endinterface

### src/asic_crosstalk_coincidence_filter.sv
// Crosstalk coincidence filter for the hits of one front-end ASIC.
//
// hit (valid/ready): one word per hit with channel, tdc_count and last.
//   Hits are taken one per cycle while the block is loading; up to MAX_HITS
//   are kept, later ones are dropped and flag overflow on the whole group.
// result (valid/ready): one word per kept hit, in load order, on the group's
//   close; last_result marks the final word of the group.
// cfg_we/cfg_index/cfg_data: register writes (0 enable, 1 window, 2 min hits).
//
// For a group of c kept hits, with filtering on, a ranking pass over the TDC
// store is followed by a window search over at most c*(c-1)/2 windows tried;
// both share one read address on the stores and one shared subtractor. Results
// then leave one by one, reading the channel and rank stores. hit.ready is low
// from the close of a group until its last result is registered.
// The output register decouples the sides: the next group loads while the
// final result waits; a stalled receiver holds results and stretches emission.
// Reset (synchronous) empties the group and restores register defaults.
module asic_crosstalk_coincidence_filter #(
  parameter int MAX_HITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  ccf_hit_if.sink                          hit,
  ccf_res_if.source                        result,
  input  logic                             cfg_we,
  input  logic [ccf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccf_pkg::CFG_W-1:0]        cfg_data
);

  localparam int IW   = $clog2(MAX_HITS);
  localparam int CW   = $clog2(MAX_HITS + 1);
  localparam int CMPW = (CW > ccf_pkg::MINH_W) ? CW : ccf_pkg::MINH_W;

  ccf_pkg::state_t state, state_next;

  logic                        enable;
  logic [ccf_pkg::WIN_W-1:0]   window;
  logic [ccf_pkg::MINH_W-1:0]  min_hits;
  logic [ccf_pkg::MINH_W-1:0]  minh;

  logic [CW-1:0]               cnt;
  logic                        dropped;
  logic [IW-1:0]               i;
  logic [CW-1:0]               j;
  logic                        pend;
  logic [IW-1:0]               pend_j;
  logic [IW-1:0]               acc;
  logic [IW-1:0]               acc_next;
  logic [ccf_pkg::TDC_W-1:0]   cur;
  logic [CW-1:0]               n;
  logic [IW-1:0]               k;
  logic [ccf_pkg::TDC_W-1:0]   lo;
  logic                        found;
  logic [IW-1:0]               win_lo;
  logic [IW-1:0]               win_hi;
  logic [IW-1:0]               e;

  logic                        ovalid;
  logic [ccf_pkg::CH_W-1:0]    o_channel;
  logic                        o_crosstalk;
  logic                        o_overflow;
  logic                        o_last;

  logic                        accept;
  logic                        full;
  logic [CW-1:0]               cnt_after;
  logic                        filter_go;
  logic                        hit_ready;
  logic [IW-1:0]               rd_addr;
  logic                        ld_we;
  logic                        rk_we;
  logic                        out_load;
  logic                        e_last;
  logic [CW-1:0]               k_ext;
  logic [CW-1:0]               hi_idx;
  logic                        k_fits;
  logic                        n_fits;

  logic [ccf_pkg::TDC_W-1:0]   tdc_rd;
  logic [ccf_pkg::TDC_W-1:0]   stdc_rd;
  logic [ccf_pkg::CH_W-1:0]    chan_rd;
  logic [IW-1:0]               rank_rd;

  logic [ccf_pkg::TDC_W-1:0]   alu_a;
  logic [ccf_pkg::TDC_W:0]     diff;
  logic                        less;
  logic                        in_win;
  logic                        mark;

  // stores
  ccf_ram #(.WIDTH(ccf_pkg::TDC_W), .DEPTH(MAX_HITS)) u_tdc_ram (
    .clk(clk), .we(ld_we), .waddr(cnt[IW-1:0]), .wdata(hit.tdc_count),
    .raddr(rd_addr), .rdata(tdc_rd)
  );

  ccf_ram #(.WIDTH(ccf_pkg::CH_W), .DEPTH(MAX_HITS)) u_chan_ram (
    .clk(clk), .we(ld_we), .waddr(cnt[IW-1:0]), .wdata(hit.channel),
    .raddr(rd_addr), .rdata(chan_rd)
  );

  // rank of each hit, by load index
  ccf_ram #(.WIDTH(IW), .DEPTH(MAX_HITS)) u_rank_ram (
    .clk(clk), .we(rk_we), .waddr(i), .wdata(acc_next),
    .raddr(rd_addr), .rdata(rank_rd)
  );

  // TDC counts in sorted order
  ccf_ram #(.WIDTH(ccf_pkg::TDC_W), .DEPTH(MAX_HITS)) u_stdc_ram (
    .clk(clk), .we(rk_we), .waddr(acc_next), .wdata(cur),
    .raddr(rd_addr), .rdata(stdc_rd)
  );

  assign accept    = hit.valid && hit_ready;
  assign full      = (cnt == CW'(MAX_HITS));
  assign cnt_after = full ? cnt : cnt + 1'b1;
  assign filter_go = enable && (CMPW'(cnt_after) >= CMPW'(min_hits));
  assign minh      = (min_hits < ccf_pkg::MINH_FLOOR) ? ccf_pkg::MINH_FLOOR : min_hits;
  assign e_last    = ((CW'(e) + 1'b1) == cnt);
  assign k_ext     = CW'(k);
  assign hi_idx    = k_ext + n - 1'b1;
  assign k_fits    = ((k_ext + n) < cnt);
  assign n_fits    = (CMPW'(n) > CMPW'(minh));

  // shared subtractor: rank compare and window span
  assign alu_a  = (state == ccf_pkg::ST_RK_CMP) ? tdc_rd : stdc_rd;
  assign diff   = {1'b0, alu_a} - {1'b0, (state == ccf_pkg::ST_RK_CMP) ? cur : lo};
  assign less   = diff[ccf_pkg::TDC_W] || ((diff == '0) && (pend_j < i));
  assign in_win = !diff[ccf_pkg::TDC_W] &&
                  (diff[ccf_pkg::TDC_W-1:0] <= ccf_pkg::TDC_W'(window));
  assign acc_next = acc + IW'(pend && less);

  assign mark = found && (rank_rd >= win_lo) && (rank_rd <= win_hi);

  always_comb begin
    hit_ready = 1'b0;
    rd_addr   = '0;
    ld_we     = 1'b0;
    rk_we     = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ccf_pkg::ST_LOAD: begin
        hit_ready = 1'b1;
        ld_we     = hit.valid && !full;
      end
      ccf_pkg::ST_RK_LD:  rd_addr = i;
      ccf_pkg::ST_RK_CUR: rd_addr = i;
      ccf_pkg::ST_RK_CMP: begin
        rd_addr = j[IW-1:0];
        rk_we   = pend && (j == cnt);
      end
      ccf_pkg::ST_SR_LO:  rd_addr = k;
      ccf_pkg::ST_SR_HI:  rd_addr = hi_idx[IW-1:0];
      ccf_pkg::ST_SR_CMP: rd_addr = hi_idx[IW-1:0];
      ccf_pkg::ST_EM_RD:  rd_addr = e;
      ccf_pkg::ST_EM_WAIT: begin
        rd_addr  = e;
        out_load = !ovalid || result.ready;
      end
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ccf_pkg::ST_LOAD: begin
        if (accept && hit.last) begin
          state_next = filter_go ? ccf_pkg::ST_RK_LD : ccf_pkg::ST_EM_RD;
        end
      end
      ccf_pkg::ST_RK_LD:  state_next = ccf_pkg::ST_RK_CUR;
      ccf_pkg::ST_RK_CUR: state_next = ccf_pkg::ST_RK_CMP;
      ccf_pkg::ST_RK_CMP: begin
        if (rk_we) begin
          if ((CW'(i) + 1'b1) != cnt) begin
            state_next = ccf_pkg::ST_RK_LD;
          end else if (CMPW'(cnt) >= CMPW'(minh)) begin
            state_next = ccf_pkg::ST_SR_LO;
          end else begin
            state_next = ccf_pkg::ST_EM_RD;
          end
        end
      end
      ccf_pkg::ST_SR_LO: state_next = ccf_pkg::ST_SR_HI;
      ccf_pkg::ST_SR_HI: state_next = ccf_pkg::ST_SR_CMP;
      ccf_pkg::ST_SR_CMP: begin
        if (in_win) begin
          state_next = ccf_pkg::ST_EM_RD;
        end else if (k_fits || n_fits) begin
          state_next = ccf_pkg::ST_SR_LO;
        end else begin
          state_next = ccf_pkg::ST_EM_RD;
        end
      end
      ccf_pkg::ST_EM_RD: state_next = ccf_pkg::ST_EM_WAIT;
      ccf_pkg::ST_EM_WAIT: begin
        if (out_load) begin
          state_next = e_last ? ccf_pkg::ST_LOAD : ccf_pkg::ST_EM_RD;
        end
      end
      default: state_next = ccf_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ccf_pkg::ST_LOAD;
      enable   <= 1'b0;
      window   <= ccf_pkg::WINDOW_RST;
      min_hits <= ccf_pkg::MINH_RST;
      cnt      <= '0;
      dropped  <= 1'b0;
      found    <= 1'b0;
      ovalid   <= 1'b0;
      i        <= '0;
      j        <= '0;
      pend     <= 1'b0;
      acc      <= '0;
      e        <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          ccf_pkg::CFG_ENABLE:   enable   <= cfg_data[0];
          ccf_pkg::CFG_WINDOW:   window   <= cfg_data[ccf_pkg::WIN_W-1:0];
          ccf_pkg::CFG_MIN_HITS: min_hits <= cfg_data[ccf_pkg::MINH_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        ovalid <= 1'b1;
      end else if (result.ready) begin
        ovalid <= 1'b0;
      end

      unique case (state)
        ccf_pkg::ST_LOAD: begin
          if (accept) begin
            cnt <= cnt_after;
            if (full) begin
              dropped <= 1'b1;
            end
            i <= '0;
          end
        end
        ccf_pkg::ST_RK_LD: ;
        ccf_pkg::ST_RK_CUR: begin
          cur  <= tdc_rd;
          j    <= '0;
          pend <= 1'b0;
          acc  <= '0;
        end
        ccf_pkg::ST_RK_CMP: begin
          pend   <= (j < cnt);
          pend_j <= j[IW-1:0];
          acc    <= acc_next;
          if (j < cnt) begin
            j <= j + 1'b1;
          end
          if (rk_we) begin
            i <= i + 1'b1;
            n <= cnt;
            k <= '0;
          end
        end
        ccf_pkg::ST_SR_LO: ;
        ccf_pkg::ST_SR_HI: lo <= stdc_rd;
        ccf_pkg::ST_SR_CMP: begin
          if (in_win) begin
            found  <= 1'b1;
            win_lo <= k;
            win_hi <= hi_idx[IW-1:0];
          end else if (k_fits) begin
            k <= k + 1'b1;
          end else begin
            n <= n - 1'b1;
            k <= '0;
          end
        end
        ccf_pkg::ST_EM_RD: ;
        ccf_pkg::ST_EM_WAIT: begin
          if (out_load) begin
            o_channel   <= chan_rd;
            o_crosstalk <= mark;
            o_overflow  <= dropped;
            o_last      <= e_last;
            if (e_last) begin
              cnt     <= '0;
              dropped <= 1'b0;
              found   <= 1'b0;
              e       <= '0;
            end else begin
              e <= e + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign hit.ready          = hit_ready;
  assign result.valid       = ovalid;
  assign result.hit_channel = o_channel;
  assign result.crosstalk   = o_crosstalk;
  assign result.overflow    = o_overflow;
  assign result.last_result = o_last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_HITS))
    else $error("hit count beyond store depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ccf_pkg::ST_EM_RD) |-> (cnt != '0))
    else $error("emission with empty group");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    found |-> (win_hi > win_lo) && (CW'(win_hi) < cnt))
    else $error("found window malformed");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    rk_we |-> (CW'(acc_next) < cnt))
    else $error("rank outside group");

  a_group_close: assert property (@(posedge clk) disable iff (rst)
    (out_load && e_last) |=> (state == ccf_pkg::ST_LOAD) && (cnt == '0) && !found)
    else $error("group not cleared after last result");

endmodule

### src/ccf_ram.sv
module ccf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_HITS       = 8;
  localparam int N_DIRECTED     = 32;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 34;
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [ccf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic {ROW_HIT, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [ccf_pkg::CH_W-1:0]  ch;
    logic [ccf_pkg::TDC_W-1:0] tdc;
    logic                      lst;
  } hit_word_t;

  typedef struct packed {
    logic [ccf_pkg::CH_W-1:0] ch;
    logic                     xt;
    logic                     ovf;
    logic                     lst;
  } filt_res_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [ccf_pkg::CFG_IDX_W-1:0] idx;
    logic [ccf_pkg::CFG_W-1:0]     data;
    hit_word_t                     w;
    logic                          typed;
    logic [MAX_HITS-1:0]           t_xt;
    logic                          t_ovf;
  } dir_row_t;

  function automatic dir_row_t hit_row(int ch, int tdc, bit lst, bit typed,
                                       logic [MAX_HITS-1:0] t_xt, bit t_ovf);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_HIT;
    r.w.ch  = ch[ccf_pkg::CH_W-1:0];
    r.w.tdc = tdc[ccf_pkg::TDC_W-1:0];
    r.w.lst = lst;
    r.typed = typed;
    r.t_xt  = t_xt;
    r.t_ovf = t_ovf;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [ccf_pkg::CFG_IDX_W-1:0] idx,
                                       logic [ccf_pkg::CFG_W-1:0] data);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // typed expectations: bit i of t_xt is the crosstalk flag of result i
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    hit_row(0, 0, 1, 1, 8'h00, 0),
    hit_row(7, 32767, 0, 0, 8'h00, 0),
    hit_row(1, 32767, 0, 0, 8'h00, 0),
    hit_row(2, 32760, 0, 0, 8'h00, 0),
    hit_row(3, 32767, 1, 1, 8'h00, 0),
    cfg_row(ccf_pkg::CFG_ENABLE, 8'h01),
    hit_row(1, 100, 0, 0, 8'h00, 0),
    hit_row(2, 105, 0, 0, 8'h00, 0),
    hit_row(3, 110, 0, 0, 8'h00, 0),
    hit_row(4, 116, 1, 1, 8'h0F, 0),
    hit_row(5, 0, 0, 0, 8'h00, 0),
    hit_row(6, 0, 0, 0, 8'h00, 0),
    hit_row(7, 0, 1, 1, 8'h00, 0),
    cfg_row(ccf_pkg::CFG_WINDOW, 8'h00),
    cfg_row(ccf_pkg::CFG_MIN_HITS, 8'h02),
    hit_row(7, 32767, 0, 0, 8'h00, 0),
    hit_row(0, 5, 0, 0, 8'h00, 0),
    hit_row(5, 32767, 1, 0, 8'h00, 0),
    hit_row(2, 9, 0, 0, 8'h00, 0),
    hit_row(3, 9, 0, 0, 8'h00, 0),
    hit_row(4, 8, 1, 0, 8'h00, 0),
    cfg_row(ccf_pkg::CFG_WINDOW, 8'hFF),
    cfg_row(ccf_pkg::CFG_MIN_HITS, 8'h08),
    hit_row(0, 0, 0, 0, 8'h00, 0),
    hit_row(1, 30, 0, 0, 8'h00, 0),
    hit_row(2, 60, 0, 0, 8'h00, 0),
    hit_row(3, 90, 0, 0, 8'h00, 0),
    hit_row(4, 120, 0, 0, 8'h00, 0),
    hit_row(5, 150, 0, 0, 8'h00, 0),
    hit_row(6, 180, 0, 0, 8'h00, 0),
    hit_row(7, 210, 0, 0, 8'h00, 0),
    hit_row(6, 240, 1, 1, 8'hFF, 1)
  };

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_we;
  logic [ccf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ccf_pkg::CFG_W-1:0]     cfg_data;

  ccf_hit_if hit_bus();
  ccf_res_if res_bus();

  asic_crosstalk_coincidence_filter #(.MAX_HITS(MAX_HITS)) uut (
    .clk       (clk),
    .rst       (rst),
    .hit       (hit_bus),
    .result    (res_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // filter model state
  logic                       xt_enable;
  logic [ccf_pkg::WIN_W-1:0]  xt_window;
  logic [ccf_pkg::MINH_W-1:0] xt_min_hits;
  logic [ccf_pkg::TDC_W-1:0]  tdc_held [MAX_HITS];
  logic [ccf_pkg::CH_W-1:0]   ch_held  [MAX_HITS];
  logic [MAX_HITS-1:0]        xt_held;
  int                         held_count;
  logic                       drop_seen;

  filt_res_t pending_results [$];
  int        errors = 0;
  int        src_idle_pct;
  int        snk_stall_pct;
  int        quiet_cycles;

  function automatic void cfg_update(logic [ccf_pkg::CFG_IDX_W-1:0] idx,
                                     logic [ccf_pkg::CFG_W-1:0] data);
    case (idx)
      ccf_pkg::CFG_ENABLE:   xt_enable   = data[0];
      ccf_pkg::CFG_WINDOW:   xt_window   = data[ccf_pkg::WIN_W-1:0];
      ccf_pkg::CFG_MIN_HITS: xt_min_hits = data[ccf_pkg::MINH_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void mark_coincidences();
    int order [MAX_HITS];
    int cur, j, floor_n;
    bit found;
    for (int i = 0; i < held_count; i++) order[i] = i;
    for (int i = 1; i < held_count; i++) begin
      cur = order[i];
      j = i;
      while (j > 0 && tdc_held[order[j-1]] > tdc_held[cur]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    floor_n = (xt_min_hits < ccf_pkg::MINH_FLOOR) ? int'(ccf_pkg::MINH_FLOOR)
                                                  : int'(xt_min_hits);
    found = 1'b0;
    for (int n = held_count; n >= floor_n && !found; n--) begin
      for (int k = 0; k + n <= held_count && !found; k++) begin
        if (int'(tdc_held[order[k+n-1]]) - int'(tdc_held[order[k]]) <= int'(xt_window)) begin
          for (int m = k; m < k + n; m++) xt_held[order[m]] = 1'b1;
          found = 1'b1;
        end
      end
    end
  endfunction

  function automatic int predict_hit(input hit_word_t w, output filt_res_t grp [MAX_HITS]);
    int n;
    n = 0;
    if (held_count < MAX_HITS) begin
      tdc_held[held_count] = w.tdc;
      ch_held[held_count]  = w.ch;
      xt_held[held_count]  = 1'b0;
      held_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (w.lst) begin
      if (xt_enable && held_count >= int'(xt_min_hits)) mark_coincidences();
      n = held_count;
      for (int i = 0; i < n; i++) begin
        grp[i].ch  = ch_held[i];
        grp[i].xt  = xt_held[i];
        grp[i].ovf = drop_seen;
        grp[i].lst = (i == n - 1);
      end
      held_count = 0;
      drop_seen  = 1'b0;
      xt_held    = '0;
    end
    return n;
  endfunction

  task automatic send_hit(input hit_word_t w, input bit typed,
                          input logic [MAX_HITS-1:0] t_xt, input bit t_ovf);
    filt_res_t grp [MAX_HITS];
    filt_res_t r;
    int n;
    while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      hit_bus.valid <= 1'b0;
      @(posedge clk);
    end
    hit_bus.valid     <= 1'b1;
    hit_bus.channel   <= w.ch;
    hit_bus.tdc_count <= w.tdc;
    hit_bus.last      <= w.lst;
    @(posedge clk);
    while (!hit_bus.ready) @(posedge clk);
    n = predict_hit(w, grp);
    for (int i = 0; i < n; i++) begin
      r = grp[i];
      if (typed) begin
        r.xt  = t_xt[i];
        r.ovf = t_ovf;
      end
      pending_results = {pending_results, r};
    end
  endtask

  task automatic settle();
    hit_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ccf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ccf_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_update(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one ASIC group; mostly clustered TDCs near the window, some wide, some overflowing
  task automatic random_group(inout int sent);
    hit_word_t w;
    int n, base;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
    base = $urandom_range(0, 32767);
    for (int i = 0; i < n; i++) begin
      w.ch = ccf_pkg::CH_W'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) w.tdc = ccf_pkg::TDC_W'($urandom);
      else w.tdc = ccf_pkg::TDC_W'(base + $urandom_range(0, int'(xt_window) + 4));
      w.lst = (i == n - 1);
      send_hit(w, 1'b0, '0, 1'b0);
      sent++;
    end
  endtask

  always @(posedge clk) begin
    filt_res_t got, want;
    if (rst) begin
      res_bus.ready <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        got.ch  = res_bus.hit_channel;
        got.xt  = res_bus.crosstalk;
        got.ovf = res_bus.overflow;
        got.lst = res_bus.last_result;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected word ch=%0d xt=%0b ovf=%0b last=%0b",
                   $time, got.ch, got.xt, got.ovf, got.lst);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch exp ch=%0d xt=%0b ovf=%0b last=%0b got ch=%0d xt=%0b ovf=%0b last=%0b",
                     $time, want.ch, want.xt, want.ovf, want.lst,
                     got.ch, got.xt, got.ovf, got.lst);
            errors++;
          end
        end
      end
      res_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      if ((hit_bus.valid && hit_bus.ready) || (res_bus.valid && res_bus.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("asic_crosstalk_coincidence_filter test failed");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    logic [ccf_pkg::WIN_W-1:0]  win;
    logic [ccf_pkg::MINH_W-1:0] minh;
    logic                       en;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    hit_bus.valid     <= 1'b0;
    hit_bus.channel   <= '0;
    hit_bus.tdc_count <= '0;
    hit_bus.last      <= 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    xt_enable     = 1'b0;
    xt_window     = ccf_pkg::WINDOW_RST;
    xt_min_hits   = ccf_pkg::MINH_RST;
    held_count    = 0;
    drop_seen     = 1'b0;
    xt_held       = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        settle();
        write_reg(DIRECTED[r].idx, DIRECTED[r].data);
      end else begin
        send_hit(DIRECTED[r].w, DIRECTED[r].typed, DIRECTED[r].t_xt, DIRECTED[r].t_ovf);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       win = '0;
        1:       win = '1;
        default: win = ccf_pkg::WIN_W'($urandom_range(0, 255));
      endcase
      case (p)
        2:       minh = ccf_pkg::MINH_FLOOR;
        3:       minh = 4'd8;
        4:       minh = ccf_pkg::MINH_W'($urandom_range(0, 1));
        5:       minh = ccf_pkg::MINH_W'($urandom_range(9, 15));
        default: minh = ccf_pkg::MINH_W'($urandom_range(2, 8));
      endcase
      en = (p != 6);
      write_reg(ccf_pkg::CFG_ENABLE, {7'($urandom), en});
      write_reg(ccf_pkg::CFG_WINDOW, win);
      write_reg(ccf_pkg::CFG_MIN_HITS, {4'($urandom), minh});
      if (p == 0) write_reg(CFG_UNUSED, ccf_pkg::CFG_W'($urandom));
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 71; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 71; end
        default: begin src_idle_pct = 7; snk_stall_pct = 7; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) random_group(sent);
    end

    settle();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("asic_crosstalk_coincidence_filter test passed");
    end else begin
      $display("asic_crosstalk_coincidence_filter test failed");
    end
    $finish;
  end

endmodule
